### rtl/gfde_pkg.sv
package gfde_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int STRIDE_W   = 16;
	localparam int DIM_W      = 7;
	localparam int CODE_W     = 4;
	localparam int SEQ_W      = 32;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_PROGRESS_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CODE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VISITED_CODE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRONTIER_CODE   = 3'd6;

	typedef struct packed {
		logic                progress_enable;
		logic [STRIDE_W-1:0] stride;
		logic [DIM_W-1:0]    grid_columns;
		logic [DIM_W-1:0]    grid_rows;
		logic [CODE_W-1:0]   empty_code;
		logic [CODE_W-1:0]   visited_code;
		logic [CODE_W-1:0]   frontier_code;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		progress_enable: 1'b1,
		stride:          16'd1,
		grid_columns:    7'd64,
		grid_rows:       7'd64,
		empty_code:      4'd0,
		visited_code:    4'd1,
		frontier_code:   4'd2
	};

endpackage

### rtl/gfde_cfg.sv
module gfde_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gfde_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gfde_pkg::CFG_DATA_W-1:0]    cfg_data,
	output gfde_pkg::cfg_t                     cfg
);

	gfde_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= gfde_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				gfde_pkg::REG_PROGRESS_ENABLE: begin
					cfg_q.progress_enable <= cfg_data[0];
				end
				gfde_pkg::REG_STRIDE: begin
					cfg_q.stride <= cfg_data[gfde_pkg::STRIDE_W-1:0];
				end
				gfde_pkg::REG_GRID_COLUMNS: begin
					cfg_q.grid_columns <= cfg_data[gfde_pkg::DIM_W-1:0];
				end
				gfde_pkg::REG_GRID_ROWS: begin
					cfg_q.grid_rows <= cfg_data[gfde_pkg::DIM_W-1:0];
				end
				gfde_pkg::REG_EMPTY_CODE: begin
					cfg_q.empty_code <= cfg_data[gfde_pkg::CODE_W-1:0];
				end
				gfde_pkg::REG_VISITED_CODE: begin
					cfg_q.visited_code <= cfg_data[gfde_pkg::CODE_W-1:0];
				end
				gfde_pkg::REG_FRONTIER_CODE: begin
					cfg_q.frontier_code <= cfg_data[gfde_pkg::CODE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/gfde_store.sv
module gfde_store #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] fwd_data_q;
	logic              fwd_q;

	// read-before-write array; a write landing on the address read at the
	// same edge is bypassed through fwd_data_q
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (rd_addr == wr_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

	a_fwd_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fwd_q) |-> $past(wr_en) && $past(rd_en))
		else $error("bypass armed without a colliding write");

endmodule

### rtl/gfde_out.sv
module gfde_out #(
	parameter int ROW_W  = 6,
	parameter int COL_W  = 6,
	parameter int CELL_W = 4,
	parameter int CNT_W  = 13,
	parameter int OUT_W  = 80
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          delta_in,
	input  logic                          summary_in,
	input  logic                          delta_last_in,
	input  logic [ROW_W-1:0]              row_in,
	input  logic [COL_W-1:0]              col_in,
	input  logic [CELL_W-1:0]             value_in,
	input  logic [CNT_W-1:0]              visited_in,
	input  logic [CNT_W-1:0]              frontier_in,
	input  logic [gfde_pkg::SEQ_W-1:0]    seq_in,
	output logic                          ready,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [OUT_W-1:0]              m_axis_tdata,
	output logic                          m_axis_tuser,
	output logic                          m_axis_tlast
);

	logic                       delta_v_q;
	logic                       summ_v_q;
	logic                       delta_last_q;
	logic [ROW_W-1:0]           row_q;
	logic [COL_W-1:0]           col_q;
	logic [CELL_W-1:0]          value_q;
	logic [CNT_W-1:0]           visited_q;
	logic [CNT_W-1:0]           frontier_q;
	logic [gfde_pkg::SEQ_W-1:0] seq_q;
	logic                       pop;

	assign m_axis_tvalid = delta_v_q || summ_v_q;
	assign pop           = m_axis_tvalid && m_axis_tready;
	// room for a new pair once at most the last pending result is leaving
	assign ready         = !m_axis_tvalid || (m_axis_tready && (delta_v_q ^ summ_v_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_v_q <= 1'b0;
			summ_v_q  <= 1'b0;
		end else if (load) begin
			delta_v_q <= delta_in;
			summ_v_q  <= summary_in;
		end else if (pop) begin
			if (delta_v_q) begin
				delta_v_q <= 1'b0;
			end else begin
				summ_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			delta_last_q <= delta_last_in;
			row_q        <= row_in;
			col_q        <= col_in;
			value_q      <= value_in;
			visited_q    <= visited_in;
			frontier_q   <= frontier_in;
			seq_q        <= seq_in;
		end
	end

	// delta goes first; a delta shows zero summary fields and vice versa
	always_comb begin
		if (delta_v_q) begin
			m_axis_tdata = OUT_W'({{gfde_pkg::SEQ_W{1'b0}}, {CNT_W{1'b0}}, {CNT_W{1'b0}},
				value_q, col_q, row_q});
			m_axis_tuser = 1'b0;
			m_axis_tlast = delta_last_q;
		end else begin
			m_axis_tdata = OUT_W'({seq_q, frontier_q, visited_q,
				{CELL_W{1'b0}}, {COL_W{1'b0}}, {ROW_W{1'b0}}});
			m_axis_tuser = 1'b1;
			m_axis_tlast = 1'b1;
		end
	end

	a_pair_delta_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		delta_v_q && summ_v_q |-> !delta_last_q)
		else $error("delta marked last while a summary follows");

endmodule

### rtl/grid_frame_delta_emitter.sv
// A cell passes the stage 1 and output registers before its result is offered. One
// cell per cycle unless the result stream stalls; a cell giving a delta plus a
// summary holds the output register for two transfers, so the next cell waits until
// one has left. The frame store is one synchronous-read array, read on accept and
// written as an emitted cell leaves stage 1, with a bypass when both hit one entry
// at the same edge. Reset clears counters, flags, config to defaults; store undefined.
module grid_frame_delta_emitter #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64,
	parameter int CELL_BITS   = 4,
	localparam int COL_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
	localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int CNT_W    = $clog2(MAX_ROWS * MAX_COLUMNS + 1),
	localparam int IN_W     = ((CELL_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = ROW_W + COL_W + CELL_BITS + 2 * CNT_W + gfde_pkg::SEQ_W,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// cell stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [IN_W-1:0]                    s_axis_tdata,  // [CELL_BITS-1:0] cell_value
	input  logic                               s_axis_tuser,  // force_frame
	// result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// from bit 0: row_index, column_index, new_value, visited_total,
	// frontier_total, sequence_res, zero fill
	output logic [OUT_W-1:0]                   m_axis_tdata,
	output logic                               m_axis_tuser,  // is_summary
	output logic                               m_axis_tlast,  // last_of_item
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gfde_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gfde_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CMP_W    = (CELL_BITS > gfde_pkg::CODE_W) ? CELL_BITS : gfde_pkg::CODE_W;
	localparam int DW       = 10;                       // holds dims and counter+1 up to 1023
	localparam int PH_W     = gfde_pkg::STRIDE_W + 1;

	gfde_pkg::cfg_t cfg;

	gfde_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// ---------------- frame position and frame-level state ----------------
	logic [ROW_W-1:0]                row_q;
	logic [COL_W-1:0]                col_q;
	logic [gfde_pkg::STRIDE_W-1:0]   phase_q;
	logic                            active_q;     // current frame is emitted
	logic                            emitted_q;    // any frame emitted yet
	logic [CNT_W-1:0]                visited_q;
	logic [CNT_W-1:0]                frontier_q;
	logic [gfde_pkg::SEQ_W-1:0]      seq_q;

	logic                            accept;
	logic [CELL_BITS-1:0]            cell_in;
	logic                            first;
	logic [DW-1:0]                   cols;
	logic [DW-1:0]                   rows;
	logic [DW-1:0]                   col_inc;
	logic [DW-1:0]                   row_inc;
	logic                            last_col;
	logic                            last_cell;
	logic [PH_W-1:0]                 eff_stride;
	logic [gfde_pkg::STRIDE_W-1:0]   phase_cur;
	logic [PH_W-1:0]                 phase_inc;
	logic [gfde_pkg::STRIDE_W-1:0]   phase_nx;
	logic                            emit_now;
	logic [CNT_W-1:0]                visited_nx;
	logic [CNT_W-1:0]                frontier_nx;
	logic [CMP_W-1:0]                cell_x;

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign cell_in = s_axis_tdata[CELL_BITS-1:0];
	assign cell_x  = CMP_W'(cell_in);
	assign first   = (row_q == '0) && (col_q == '0);

	// clamp the configured size to 1..MAX
	always_comb begin
		cols = DW'(cfg.grid_columns);
		if (cols == '0) begin
			cols = DW'(1);
		end else if (cols > DW'(MAX_COLUMNS)) begin
			cols = DW'(MAX_COLUMNS);
		end
		rows = DW'(cfg.grid_rows);
		if (rows == '0) begin
			rows = DW'(1);
		end else if (rows > DW'(MAX_ROWS)) begin
			rows = DW'(MAX_ROWS);
		end
	end

	assign col_inc   = DW'(col_q) + DW'(1);
	assign row_inc   = DW'(row_q) + DW'(1);
	assign last_col  = col_inc >= cols;
	assign last_cell = last_col && (row_inc >= rows);

	// stride phase: a phase at or past the stride wraps; zero stride acts as one
	assign eff_stride = (cfg.stride == '0) ? PH_W'(1) : PH_W'(cfg.stride);
	assign phase_cur  = (PH_W'(phase_q) >= eff_stride) ? '0 : phase_q;
	assign phase_inc  = PH_W'(phase_cur) + PH_W'(1);
	assign phase_nx   = (phase_inc >= eff_stride) ? '0 : phase_inc[gfde_pkg::STRIDE_W-1:0];

	// emit decision is taken at the first cell and held for the frame
	assign emit_now = first ? (s_axis_tuser || (cfg.progress_enable && (phase_cur == '0)))
	                        : active_q;

	assign visited_nx  = (first ? '0 : visited_q)
	                   + CNT_W'(emit_now && (cell_x == CMP_W'(cfg.visited_code)));
	assign frontier_nx = (first ? '0 : frontier_q)
	                   + CNT_W'(emit_now && (cell_x == CMP_W'(cfg.frontier_code)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			phase_q    <= '0;
			active_q   <= 1'b0;
			emitted_q  <= 1'b0;
			visited_q  <= '0;
			frontier_q <= '0;
			seq_q      <= '0;
		end else if (accept) begin
			if (first) begin
				phase_q <= phase_nx;
			end
			active_q   <= emit_now && !last_cell;
			visited_q  <= visited_nx;
			frontier_q <= frontier_nx;
			if (last_cell) begin
				row_q <= '0;
				col_q <= '0;
			end else if (last_col) begin
				row_q <= row_inc[ROW_W-1:0];
				col_q <= '0;
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
			if (emit_now && last_cell) begin
				seq_q     <= seq_q + gfde_pkg::SEQ_W'(1);
				emitted_q <= 1'b1;
			end
		end
	end

	// ---------------- stage 1: store read returns, compare ----------------
	logic                         s1_v_q;
	logic                         emit_s1;
	logic                         emitted_s1;
	logic                         last_s1;
	logic [ROW_W-1:0]             row_s1;
	logic [COL_W-1:0]             col_s1;
	logic [CELL_BITS-1:0]         cell_s1;
	logic [CNT_W-1:0]             visited_s1;
	logic [CNT_W-1:0]             frontier_s1;
	logic [gfde_pkg::SEQ_W-1:0]   seq_s1;

	logic                         out_ready;
	logic                         s1_adv;
	logic                         store_we;
	logic [CELL_BITS-1:0]         prev_cell;
	logic                         changed;

	assign s1_adv        = s1_v_q && out_ready;
	assign s_axis_tready = !s1_v_q || out_ready;
	assign store_we      = s1_adv && emit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1     <= emit_now;
			emitted_s1  <= emitted_q;
			last_s1     <= last_cell;
			row_s1      <= row_q;
			col_s1      <= col_q;
			cell_s1     <= cell_in;
			visited_s1  <= visited_nx;
			frontier_s1 <= frontier_nx;
			seq_s1      <= seq_q;
		end
	end

	gfde_store #(
		.ADDR_W (ROW_W + COL_W),
		.DATA_W (CELL_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr ({row_q, col_q}),
		.wr_en   (store_we),
		.wr_addr ({row_s1, col_s1}),
		.wr_data (cell_s1),
		.rd_data (prev_cell)
	);

	// until the first emitted frame has ended, compare against the empty code
	assign changed = emitted_s1 ? (cell_s1 != prev_cell)
	                            : (CMP_W'(cell_s1) != CMP_W'(cfg.empty_code));

	gfde_out #(
		.ROW_W  (ROW_W),
		.COL_W  (COL_W),
		.CELL_W (CELL_BITS),
		.CNT_W  (CNT_W),
		.OUT_W  (OUT_W)
	) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (s1_adv),
		.delta_in      (emit_s1 && changed),
		.summary_in    (emit_s1 && last_s1),
		.delta_last_in (!last_s1),
		.row_in        (row_s1),
		.col_in        (col_s1),
		.value_in      (cell_s1),
		.visited_in    (visited_s1),
		.frontier_in   (frontier_s1),
		.seq_in        (seq_s1),
		.ready         (out_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(DW'(row_q) < DW'(MAX_ROWS)) && (DW'(col_q) < DW'(MAX_COLUMNS)))
		else $error("frame position outside the grid");

	a_seq_on_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != $past(seq_q)) |-> $past(accept && emit_now && last_cell))
		else $error("sequence moved without an emitted frame end");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !s1_v_q || s1_adv)
		else $error("stage 1 overwritten while holding a request");

endmodule

### verif/tb_grid_frame_delta_emitter.sv
`timescale 1ns / 1ps

module tb_grid_frame_delta_emitter;

	// stream widths: one 4-bit cell code padded to a byte; 74 result bits padded to 80
	localparam int IN_W          = 8;
	localparam int OUT_W         = 80;
	localparam int MAX_COLUMNS   = 64;
	localparam int MAX_ROWS      = 64;
	localparam int BOX_ROWS      = 6;    // rows written by the opening frame
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 300;
	localparam int NUM_PHASES    = 10;
	localparam int PHASE_ITEMS   = 155;
	localparam int PRESSURE_PHASE = 4;
	localparam int PLAN_LEN      = 45;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_t;
	typedef enum logic [1:0] {ROW_CELL, ROW_WRITE, ROW_FILL} plan_kind_t;
	// how a directed row gets its expected results
	typedef enum logic [1:0] {OUT_PREDICTED, OUT_NONE, OUT_ONE} known_t;

	// field order matches the result bus, is_summary down to last_of_item
	typedef struct packed {
		logic        is_summary;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [3:0]  value;
		logic [12:0] visited;
		logic [12:0] frontier;
		logic [31:0] seq;
		logic        last;
	} update_t;

	typedef struct packed {
		plan_kind_t  kind;
		logic [2:0]  reg_idx;
		logic [15:0] value;   // register data, or the cell code in bits 3:0
		logic        forced;
		known_t      known;
		update_t     given;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;   // [3:0] cell_value, [7:4] zero
	logic s_axis_tuser;              // force_frame
	logic m_axis_tvalid;
	logic m_axis_tready;
	// [5:0] row_index, [11:6] column_index, [15:12] new_value, [28:16] visited_total,
	// [41:29] frontier_total, [73:42] sequence_res, [79:74] zero
	logic [OUT_W-1:0] m_axis_tdata;
	logic m_axis_tuser;              // is_summary
	logic m_axis_tlast;              // last_of_item
	logic cfg_valid;
	logic cfg_ready;
	logic [gfde_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gfde_pkg::CFG_DATA_W-1:0] cfg_data;

	idle_t idle_mode;
	int hold_requests;
	int mismatch_count;

	// frame tracker: shadow config plus a copy of the block's frame state
	gfde_pkg::cfg_t grid_cfg;
	logic [3:0] stored_cell [MAX_ROWS*MAX_COLUMNS];
	bit has_emitted;
	bit emit_on;
	int unsigned stride_phase;
	int unsigned row_at, col_at;
	logic [12:0] visited_run, frontier_run;
	logic [31:0] seq_next;
	update_t fresh [2];
	update_t awaited_updates [$];

	bit seen_fire;
	update_t seen_update;

	always #6 clk = ~clk;

	grid_frame_delta_emitter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Directed rows. The opening 64-column, six-row frame is the first emitted
	// one, so it writes every store entry of those rows; later frames never go
	// past six rows and only read written entries. Typed results only where
	// they follow directly from reset state.
	plan_row_t plan [PLAN_LEN] = '{
		'{ROW_WRITE, gfde_pkg::REG_GRID_ROWS, 16'(BOX_ROWS), 1'b0, OUT_PREDICTED, '0},
		// first cell is the empty code: frame emits, but nothing to report
		'{ROW_CELL, '0, 16'd0, 1'b0, OUT_NONE, '0},
		'{ROW_CELL, '0, 16'd15, 1'b0, OUT_ONE, '{1'b0, 6'd0, 6'd1, 4'd15, 13'd0, 13'd0, 32'd0, 1'b1}},
		'{ROW_CELL, '0, 16'd1, 1'b0, OUT_ONE, '{1'b0, 6'd0, 6'd2, 4'd1, 13'd0, 13'd0, 32'd0, 1'b1}},
		'{ROW_CELL, '0, 16'd2, 1'b0, OUT_ONE, '{1'b0, 6'd0, 6'd3, 4'd2, 13'd0, 13'd0, 32'd0, 1'b1}},
		// rest of the opening frame; the last cell gives the summary, after a delta if its code changed
		'{ROW_FILL, '0, 16'd0, 1'b0, OUT_PREDICTED, '0},
		// 2x2 frames, zero stride acts as one
		'{ROW_WRITE, gfde_pkg::REG_GRID_COLUMNS, 16'd2, 1'b0, OUT_PREDICTED, '0},
		'{ROW_WRITE, gfde_pkg::REG_GRID_ROWS, 16'd2, 1'b0, OUT_PREDICTED, '0},
		'{ROW_WRITE, gfde_pkg::REG_STRIDE, 16'd0, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd15, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd0, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd7, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd15, 1'b0, OUT_PREDICTED, '0},
		// code extremes, visited and empty share a code
		'{ROW_WRITE, gfde_pkg::REG_EMPTY_CODE, 16'd15, 1'b0, OUT_PREDICTED, '0},
		'{ROW_WRITE, gfde_pkg::REG_VISITED_CODE, 16'd15, 1'b0, OUT_PREDICTED, '0},
		'{ROW_WRITE, gfde_pkg::REG_FRONTIER_CODE, 16'd0, 1'b0, OUT_PREDICTED, '0},
		// progress off: unforced frame is silent, forced frame emits
		'{ROW_WRITE, gfde_pkg::REG_PROGRESS_ENABLE, 16'd0, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd15, 1'b0, OUT_NONE, '0},
		'{ROW_CELL, '0, 16'd0, 1'b0, OUT_NONE, '0},
		'{ROW_CELL, '0, 16'd3, 1'b0, OUT_NONE, '0},
		'{ROW_CELL, '0, 16'd15, 1'b0, OUT_NONE, '0},
		'{ROW_CELL, '0, 16'd0, 1'b1, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd15, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd15, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd9, 1'b0, OUT_PREDICTED, '0},
		// zero sizes clamp to 1x1: every cell is a frame, stride 3
		'{ROW_WRITE, gfde_pkg::REG_PROGRESS_ENABLE, 16'd1, 1'b0, OUT_PREDICTED, '0},
		'{ROW_WRITE, gfde_pkg::REG_GRID_COLUMNS, 16'd0, 1'b0, OUT_PREDICTED, '0},
		'{ROW_WRITE, gfde_pkg::REG_GRID_ROWS, 16'd0, 1'b0, OUT_PREDICTED, '0},
		'{ROW_WRITE, gfde_pkg::REG_STRIDE, 16'd3, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd4, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd5, 1'b0, OUT_PREDICTED, '0},
		// stride lowered below the running phase: phase wraps
		'{ROW_WRITE, gfde_pkg::REG_STRIDE, 16'd2, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd6, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd0, 1'b1, OUT_PREDICTED, '0},
		// widest stride, then the grid shrinks under a frame in flight
		'{ROW_WRITE, gfde_pkg::REG_STRIDE, 16'd65535, 1'b0, OUT_PREDICTED, '0},
		'{ROW_WRITE, gfde_pkg::REG_GRID_COLUMNS, 16'd4, 1'b0, OUT_PREDICTED, '0},
		'{ROW_WRITE, gfde_pkg::REG_GRID_ROWS, 16'd2, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd1, 1'b1, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd2, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd3, 1'b0, OUT_PREDICTED, '0},
		// column 3 now past the width: ends the row
		'{ROW_WRITE, gfde_pkg::REG_GRID_COLUMNS, 16'd2, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd8, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd9, 1'b0, OUT_PREDICTED, '0},
		// row 1 now past the height: ends the frame; force mid-frame is ignored
		'{ROW_WRITE, gfde_pkg::REG_GRID_ROWS, 16'd1, 1'b0, OUT_PREDICTED, '0},
		'{ROW_CELL, '0, 16'd10, 1'b1, OUT_PREDICTED, '0}
	};

	task automatic log_mismatch(input string msg);
		mismatch_count++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input longint unsigned got,
			input longint unsigned want);
		if (got != want)
			log_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic queue_update(input update_t upd);
		awaited_updates = {awaited_updates, upd};
	endtask

	// Walks one accepted cell through the frame state. Returns the number of
	// results it causes, left in fresh[].
	function automatic int advance_frame(input logic [3:0] code, input logic forced);
		int unsigned cols, rows, span, slot;
		logic row_end, frame_end, changed;
		int n;
		n = 0;
		cols = (grid_cfg.grid_columns == 0) ? 1 :
			(grid_cfg.grid_columns > MAX_COLUMNS) ? MAX_COLUMNS : grid_cfg.grid_columns;
		rows = (grid_cfg.grid_rows == 0) ? 1 :
			(grid_cfg.grid_rows > MAX_ROWS) ? MAX_ROWS : grid_cfg.grid_rows;
		span = (grid_cfg.stride == 0) ? 1 : grid_cfg.stride;
		// emit decision and counter clear happen at the frame's first cell
		if (row_at == 0 && col_at == 0) begin
			if (stride_phase >= span)
				stride_phase = 0;
			emit_on = forced || (grid_cfg.progress_enable && stride_phase == 0);
			stride_phase = (stride_phase + 1 >= span) ? 0 : stride_phase + 1;
			visited_run = '0;
			frontier_run = '0;
		end
		row_end = col_at + 1 >= cols;
		frame_end = row_end && (row_at + 1 >= rows);
		if (emit_on) begin
			slot = row_at * MAX_COLUMNS + col_at;
			changed = has_emitted ? (code != stored_cell[slot]) : (code != grid_cfg.empty_code);
			if (code == grid_cfg.visited_code)
				visited_run++;
			if (code == grid_cfg.frontier_code)
				frontier_run++;
			stored_cell[slot] = code;
			if (changed) begin
				fresh[n] = '{1'b0, row_at[5:0], col_at[5:0], code, 13'd0, 13'd0, 32'd0,
					!frame_end};
				n++;
			end
			if (frame_end) begin
				fresh[n] = '{1'b1, 6'd0, 6'd0, 4'd0, visited_run, frontier_run, seq_next, 1'b1};
				n++;
				seq_next++;
				has_emitted = 1'b1;
			end
		end
		if (frame_end) begin
			row_at = 0;
			col_at = 0;
			emit_on = 1'b0;
		end else if (row_end) begin
			col_at = 0;
			row_at++;
		end else begin
			col_at++;
		end
		return n;
	endfunction

	// Drop the cell stream and let the block drain before touching config.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (awaited_updates.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Back-to-back writes keep cfg_valid high; the next cell request lowers it.
	task automatic write_reg(input logic [gfde_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
		bit acc;
		if (!cfg_valid)
			settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			if (acc) begin
				case (idx)
					gfde_pkg::REG_PROGRESS_ENABLE: grid_cfg.progress_enable = data[0];
					gfde_pkg::REG_STRIDE:          grid_cfg.stride = data;
					gfde_pkg::REG_GRID_COLUMNS:    grid_cfg.grid_columns = data[6:0];
					gfde_pkg::REG_GRID_ROWS:       grid_cfg.grid_rows = data[6:0];
					gfde_pkg::REG_EMPTY_CODE:      grid_cfg.empty_code = data[3:0];
					gfde_pkg::REG_VISITED_CODE:    grid_cfg.visited_code = data[3:0];
					gfde_pkg::REG_FRONTIER_CODE:   grid_cfg.frontier_code = data[3:0];
					default: ;
				endcase
			end
			@(posedge clk);
		end while (!acc);
	endtask

	// One cell request. Acceptance is judged from tready as it stands at the
	// falling edge, so the expectation is queued before the accepting edge.
	task automatic send_cell(input logic [3:0] code, input logic forced, input known_t known,
			input update_t given);
		bit acc;
		int gap_pct;
		int n;
		if (cfg_valid)
			cfg_valid <= 1'b0;
		gap_pct = (idle_mode == IDLE_SENDER) ? 49 : (idle_mode == IDLE_BOTH) ? 17 : 0;
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, code};
		s_axis_tuser <= forced;
		do begin
			@(negedge clk);
			acc = s_axis_tready;
			if (acc) begin
				n = advance_frame(code, forced);
				case (known)
					OUT_PREDICTED: for (int k = 0; k < n; k++) queue_update(fresh[k]);
					OUT_ONE:       queue_update(given);
					default: ;
				endcase
			end
			@(posedge clk);
		end while (!acc);
	endtask

	function automatic logic [6:0] pick_dim();
		case ($urandom_range(9))
			0: return 7'd0;
			1: return 7'd64;
			2: return 7'($urandom_range(65, 127));
			default: return 7'($urandom_range(1, 6));
		endcase
	endfunction

	// rows stay inside the band written by the opening frame
	function automatic logic [6:0] pick_rows();
		case ($urandom_range(5))
			0: return 7'd0;
			default: return 7'($urandom_range(1, BOX_ROWS));
		endcase
	endfunction

	function automatic logic [3:0] pick_code();
		case ($urandom_range(3))
			0: return 4'd0;
			1: return 4'd15;
			default: return 4'($urandom_range(15));
		endcase
	endfunction

	// Result side: sample at the falling edge, judge at the next rising edge.
	always @(negedge clk) begin
		seen_fire <= m_axis_tvalid && m_axis_tready;
		seen_update <= {m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tdata[15:12],
			m_axis_tdata[28:16], m_axis_tdata[41:29], m_axis_tdata[73:42], m_axis_tlast};
	end

	always @(posedge clk) begin : check_update
		update_t want;
		if (seen_fire) begin
			if (awaited_updates.size() == 0) begin
				log_mismatch($sformatf("result with nothing pending: %p", seen_update));
			end else begin
				want = awaited_updates.pop_front();
				check_field("is_summary", seen_update.is_summary, want.is_summary);
				check_field("row_index", seen_update.row, want.row);
				check_field("column_index", seen_update.col, want.col);
				check_field("new_value", seen_update.value, want.value);
				check_field("visited_total", seen_update.visited, want.visited);
				check_field("frontier_total", seen_update.frontier, want.frontier);
				check_field("sequence_res", seen_update.seq, want.seq);
				check_field("last_of_item", seen_update.last, want.last);
			end
		end
	end

	// Receiver: random backpressure per idle mode, plus long hold-offs on request.
	initial begin : receiver_side
		int served;
		int stall_pct;
		served = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				served++;
				for (int k = 0; k < HOLD_CYCLES; k++) begin
					m_axis_tready <= 1'b0;
					@(posedge clk);
				end
			end
			stall_pct = (idle_mode == IDLE_RECEIVER) ? 49 : (idle_mode == IDLE_BOTH) ? 17 : 0;
			m_axis_tready <= !($urandom_range(99) < stall_pct);
		end
	end

	initial begin : stimulus
		logic [3:0] code;
		bit pressure;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_mode = IDLE_NONE;
		hold_requests = 0;
		mismatch_count = 0;
		grid_cfg = gfde_pkg::CFG_RESET;
		has_emitted = 1'b0;
		emit_on = 1'b0;
		stride_phase = 0;
		row_at = 0;
		col_at = 0;
		visited_run = '0;
		frontier_run = '0;
		seq_next = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, both sides idling lightly
		idle_mode <= IDLE_BOTH;
		for (int i = 0; i < PLAN_LEN; i++) begin
			case (plan[i].kind)
				ROW_WRITE: write_reg(plan[i].reg_idx, plan[i].value);
				ROW_CELL:  send_cell(plan[i].value[3:0], plan[i].forced, plan[i].known,
					plan[i].given);
				default: begin
					do
						send_cell(4'($urandom_range(15)), 1'($urandom_range(1)), OUT_PREDICTED, '0);
					while (row_at != 0 || col_at != 0);
				end
			endcase
		end

		// random phases: fresh config each time, idle mode cycles through all four
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			pressure = (ph == PRESSURE_PHASE);
			// the hold-off phase needs a steady supply of results
			write_reg(gfde_pkg::REG_PROGRESS_ENABLE,
				pressure ? 16'd1 : 16'($urandom_range(3) != 0));
			case ($urandom_range(5))
				0: write_reg(gfde_pkg::REG_STRIDE, pressure ? 16'd1 : 16'd0);
				1: write_reg(gfde_pkg::REG_STRIDE, 16'd1);
				2: write_reg(gfde_pkg::REG_STRIDE, pressure ? 16'd1 : 16'($urandom_range(2, 4)));
				3: write_reg(gfde_pkg::REG_STRIDE, pressure ? 16'd1 : 16'd65535);
				4: write_reg(gfde_pkg::REG_STRIDE, pressure ? 16'd1 : 16'($urandom));
				default: write_reg(gfde_pkg::REG_STRIDE, 16'd1);
			endcase
			write_reg(gfde_pkg::REG_GRID_COLUMNS, pressure ? 16'd4 : {9'd0, pick_dim()});
			write_reg(gfde_pkg::REG_GRID_ROWS, pressure ? 16'd4 : {9'd0, pick_rows()});
			write_reg(gfde_pkg::REG_EMPTY_CODE, {12'd0, pick_code()});
			write_reg(gfde_pkg::REG_VISITED_CODE, {12'd0, pick_code()});
			write_reg(gfde_pkg::REG_FRONTIER_CODE, {12'd0, pick_code()});
			idle_mode <= idle_t'(ph % 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (pressure && n == 20)
					hold_requests <= hold_requests + 1;
				// repeats of the stored code keep some emitted cells quiet
				case ($urandom_range(9))
					0, 1, 2, 3: code = stored_cell[row_at * MAX_COLUMNS + col_at];
					4: code = grid_cfg.empty_code;
					5: code = grid_cfg.visited_code;
					6: code = grid_cfg.frontier_code;
					default: code = 4'($urandom_range(15));
				endcase
				send_cell(code, $urandom_range(7) == 0, OUT_PREDICTED, '0);
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("grid_frame_delta_emitter test passed");
		else
			$display("grid_frame_delta_emitter test failed");
		$finish;
	end

	// hard stop, several times the slowest legal run
	initial begin : watchdog
		#3_000_000;
		$display("grid_frame_delta_emitter test failed");
		$finish;
	end

endmodule

### sim.f
rtl/gfde_pkg.sv
rtl/gfde_cfg.sv
rtl/gfde_store.sv
rtl/gfde_out.sv
rtl/grid_frame_delta_emitter.sv
verif/tb_grid_frame_delta_emitter.sv
